/* hw/rtl/spq_pkg.sv */
// Package for the stable priority queue: sizes, command and status codes,
// and the types shared by the queue cells and the top level.
// No dependencies.
`default_nettype none

package spq_pkg;

  localparam int QueueDepth = 16;
  localparam int KeyBits    = 16;
  localparam int PrioBits   = 8;
  localparam int CountBits  = $clog2(QueueDepth + 1);

  typedef enum logic [1:0] {
    CmdInsert = 2'd0,
    CmdPop    = 2'd1,
    CmdQuery  = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    StOk    = 2'd0,
    StEmpty = 2'd1,
    StFull  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    OpHold,
    OpInsert,
    OpPop
  } cell_op_e;

  typedef struct packed {
    logic                valid;
    logic [KeyBits-1:0]  key;
    logic [PrioBits-1:0] prio;
  } entry_t;

  typedef struct packed {
    cell_op_e            op;
    logic [KeyBits-1:0]  key;
    logic [PrioBits-1:0] prio;
  } cell_ctrl_t;

endpackage

`default_nettype wire

/* hw/rtl/spq_if.sv */
// Handshake channels of the stable priority queue: the command channel and
// the response channel. Depends on spq_pkg.
`default_nettype none

interface spq_cmd_if
  import spq_pkg::*;
;
  logic                valid;
  logic                ready;
  logic [1:0]          command;
  logic [KeyBits-1:0]  key;
  logic [PrioBits-1:0] priority_req;

  modport source (output valid, command, key, priority_req, input ready);
  modport sink   (input valid, command, key, priority_req, output ready);
endinterface

interface spq_rsp_if
  import spq_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic [1:0]           status;
  logic                 found;
  logic [KeyBits-1:0]   out_key;
  logic [PrioBits-1:0]  out_priority;
  logic [CountBits-1:0] occupancy;

  modport source (output valid, status, found, out_key, out_priority, occupancy,
                  input ready);
  modport sink   (input valid, status, found, out_key, out_priority, occupancy,
                  output ready);
endinterface

`default_nettype wire

/* hw/rtl/stable_priority_queue.sv */
// Top level of the stable priority queue: the chain of queue cells, the
// entry counter and the response register. Depends on spq_pkg, spq_if, spq_cell.
`default_nettype none

// The queue holds up to QueueDepth entries sorted by priority in a chain of
// cells, the head in cell 0. For every command, all cells compare the
// incoming priority against their own entry at once and shift in the
// same clock edge, so a command is accepted in every cycle in which the
// single response register is empty or its response is being taken. The
// response appears in the cycle after its command transfer and holds until it
// is taken. An insert lands behind every entry of equal or higher priority,
// so equal priorities leave in arrival order. An insert into a full queue is
// dropped and answered with the full status; a pop of an empty queue is
// answered with the empty status. Command code 3 changes nothing and reports
// the current occupancy.
module stable_priority_queue
  import spq_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  spq_cmd_if.sink    cmd_i,
  spq_rsp_if.source  rsp_o
);

  entry_t [QueueDepth-1:0] entries;
  logic   [QueueDepth-1:0] go;
  logic   [QueueDepth-1:0] valid_vec;
  logic   [QueueDepth-1:0] hit_vec;
  cell_ctrl_t              ctrl;

  logic                 in_fire;
  logic                 full;
  logic                 empty;
  logic                 hit;
  cmd_e                 cmd;

  logic [CountBits-1:0] count_q, count_d;
  logic                 rsp_valid_q, rsp_valid_d;
  status_e              status_q, status_d;
  logic                 found_q, found_d;
  logic [KeyBits-1:0]   key_q, key_d;
  logic [PrioBits-1:0]  prio_q, prio_d;

  // A new command is taken whenever the response register is free or
  // drains in this cycle.
  assign cmd_i.ready = !rsp_valid_q || rsp_o.ready;
  assign in_fire     = cmd_i.valid && cmd_i.ready;
  assign cmd         = cmd_e'(cmd_i.command);

  assign full  = (count_q == CountBits'(QueueDepth));
  assign empty = (count_q == '0);

  // The chain of cells. Cell 0 sees no predecessor that moves, and the last
  // cell pulls an empty entry on pop.
  for (genvar i = 0; i < QueueDepth; i++) begin : g_cell
    entry_t prev_entry;
    entry_t next_entry;
    logic   prev_go;

    if (i == 0) begin : g_head
      assign prev_entry = '0;
      assign prev_go    = 1'b0;
    end else begin : g_body
      assign prev_entry = entries[i-1];
      assign prev_go    = go[i-1];
    end

    if (i == QueueDepth - 1) begin : g_tail
      assign next_entry = '0;
    end else begin : g_inner
      assign next_entry = entries[i+1];
    end

    spq_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (ctrl),
      .prev_i    (prev_entry),
      .prev_go_i (prev_go),
      .next_i    (next_entry),
      .entry_o   (entries[i]),
      .go_o      (go[i])
    );

    assign valid_vec[i] = entries[i].valid;
    assign hit_vec[i]   = entries[i].valid && (entries[i].key == cmd_i.key);
  end

  assign hit = |hit_vec;

  // Command decode: drives the cell operation and builds the response.
  always_comb begin
    ctrl.op     = OpHold;
    ctrl.key    = cmd_i.key;
    ctrl.prio   = cmd_i.priority_req;
    count_d     = count_q;
    status_d    = status_q;
    found_d     = found_q;
    key_d       = key_q;
    prio_d      = prio_q;
    rsp_valid_d = rsp_valid_q && !rsp_o.ready;

    if (in_fire) begin
      rsp_valid_d = 1'b1;
      status_d    = StOk;
      found_d     = 1'b0;
      key_d       = '0;
      prio_d      = '0;
      case (cmd)
        CmdInsert: begin
          if (full) begin
            status_d = StFull;
          end else begin
            ctrl.op = OpInsert;
            count_d = count_q + CountBits'(1);
          end
        end
        CmdPop: begin
          if (empty) begin
            status_d = StEmpty;
          end else begin
            ctrl.op = OpPop;
            count_d = count_q - CountBits'(1);
            key_d   = entries[0].key;
            prio_d  = entries[0].prio;
          end
        end
        CmdQuery: begin
          found_d = hit;
        end
        default: begin
          status_d = StOk;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    found_q  <= found_d;
    key_q    <= key_d;
    prio_q   <= prio_d;
  end

  assign rsp_o.valid        = rsp_valid_q;
  assign rsp_o.status       = status_q;
  assign rsp_o.found        = found_q;
  assign rsp_o.out_key      = key_q;
  assign rsp_o.out_priority = prio_q;
  assign rsp_o.occupancy    = count_q;

  // The entry counter always equals the number of occupied cells.
  a_count_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_vec) == 32'(count_q))
    else $error("entry counter disagrees with occupied cells");

  // Occupied cells form an unbroken run starting at the head.
  a_valid_prefix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_vec & (valid_vec + QueueDepth'(1))) == '0)
    else $error("occupied cells are not packed at the head");

  // A successful pop returns the entry that was at the head.
  a_pop_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && cmd == CmdPop && !empty) |=>
      (rsp_o.valid && rsp_o.out_key == $past(entries[0].key)
       && rsp_o.out_priority == $past(entries[0].prio)))
    else $error("pop did not return the head entry");

endmodule

`default_nettype wire

/* hw/rtl/spq_cell.sv */
// One slot of the sorted queue chain. Holds one entry and moves it toward
// the tail on insert or toward the head on pop. Depends on spq_pkg.
`default_nettype none

module spq_cell
  import spq_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire cell_ctrl_t ctrl_i,
  input  wire entry_t     prev_i,
  input  wire logic       prev_go_i,
  input  wire entry_t     next_i,
  output entry_t          entry_o,
  output logic            go_o
);

  entry_t entry_q;
  entry_t entry_d;

  // The new entry belongs at or ahead of this slot when the slot is empty or
  // holds a strictly lower priority; equal priorities stay ahead.
  assign go_o    = !entry_q.valid || (entry_q.prio < ctrl_i.prio);
  assign entry_o = entry_q;

  always_comb begin
    entry_d = entry_q;
    case (ctrl_i.op)
      OpInsert: begin
        if (go_o) begin
          if (prev_go_i) begin
            entry_d = prev_i;
          end else begin
            entry_d = '{valid: 1'b1, key: ctrl_i.key, prio: ctrl_i.prio};
          end
        end
      end
      OpPop: begin
        entry_d = next_i;
      end
      default: begin
        entry_d = entry_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= '0;
    end else begin
      entry_q <= entry_d;
    end
  end

endmodule

`default_nettype wire

/* tb/spq_shadow_pkg.sv */
// Shadow model of the stable priority queue for the testbench: the expected
// response type and a small scoreboard class that mirrors the sorted slots.
// Depends on spq_pkg.
`default_nettype none

package spq_shadow_pkg;
  import spq_pkg::*;

  // Command code 3 is unused by the queue and must behave as a no-op.
  localparam logic [1:0] CmdUnused = 2'd3;

  typedef struct packed {
    status_e              status;
    logic                 found;
    logic [KeyBits-1:0]   key;
    logic [PrioBits-1:0]  prio;
    logic [CountBits-1:0] occupancy;
  } spq_rsp_t;

  class queue_shadow;
    logic [KeyBits-1:0]  slot_key  [QueueDepth];
    logic [PrioBits-1:0] slot_prio [QueueDepth];
    int unsigned         fill;
    spq_rsp_t            pending_rsp [$];
    int unsigned         errors;

    function new();
      fill   = 0;
      errors = 0;
    endfunction

    // Applies one accepted command transfer to the shadow slots and queues
    // the response that it must produce.
    function void note_command(logic [1:0] cmd, logic [KeyBits-1:0] key,
                               logic [PrioBits-1:0] prio);
      spq_rsp_t    rsp;
      int unsigned pos;
      int unsigned i;
      rsp        = '0;
      rsp.status = StOk;
      case (cmd)
        CmdInsert: begin
          if (fill >= QueueDepth) begin
            rsp.status = StFull;
          end else begin
            // Land behind every entry of equal or higher priority.
            pos = 0;
            while (pos < fill && slot_prio[pos] >= prio) pos++;
            for (i = fill; i > pos; i--) begin
              slot_key[i]  = slot_key[i-1];
              slot_prio[i] = slot_prio[i-1];
            end
            slot_key[pos]  = key;
            slot_prio[pos] = prio;
            fill++;
          end
        end
        CmdPop: begin
          if (fill == 0) begin
            rsp.status = StEmpty;
          end else begin
            rsp.key  = slot_key[0];
            rsp.prio = slot_prio[0];
            for (i = 1; i < fill; i++) begin
              slot_key[i-1]  = slot_key[i];
              slot_prio[i-1] = slot_prio[i];
            end
            fill--;
          end
        end
        CmdQuery: begin
          for (i = 0; i < fill; i++) begin
            if (slot_key[i] == key) rsp.found = 1'b1;
          end
        end
        default: begin
        end
      endcase
      rsp.occupancy = CountBits'(fill);
      pending_rsp.push_back(rsp);
    endfunction

    function void compare_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
      if (exp_val !== act_val) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_val,
                 act_val);
        errors++;
      end
    endfunction

    // Checks one response transfer against the oldest outstanding one.
    function void check_response(spq_rsp_t act);
      spq_rsp_t exp;
      if (pending_rsp.size() == 0) begin
        $display("%0t: response with nothing outstanding, expected none, actual %0h",
                 $time, act);
        errors++;
      end else begin
        exp = pending_rsp.pop_front();
        compare_field("status", 32'(exp.status), 32'(act.status));
        compare_field("found", 32'(exp.found), 32'(act.found));
        compare_field("out_key", 32'(exp.key), 32'(act.key));
        compare_field("out_priority", 32'(exp.prio), 32'(act.prio));
        compare_field("occupancy", 32'(exp.occupancy), 32'(act.occupancy));
      end
    endfunction
  endclass

endpackage

`default_nettype wire

/* tb/tb_stable_priority_queue.sv */
// Testbench top for the stable priority queue: drives the command channel,
// stalls the response channel and checks every response against a shadow
// queue. Depends on spq_pkg, spq_if, spq_shadow_pkg and the queue RTL.
`default_nettype none

module tb_stable_priority_queue;
  import spq_pkg::*;
  import spq_shadow_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Far above the slowest legal run: roughly 900 commands, each waiting out
  // long sender gaps and receiver stalls, plus the drains between phases.
  localparam int unsigned CycleLimit = 200000;

  logic clk_i;
  logic rst_ni;

  spq_cmd_if cmd_if ();
  spq_rsp_if rsp_if ();

  stable_priority_queue i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_if),
    .rsp_o  (rsp_if)
  );

  queue_shadow sb = new();

  // Idle rates in percent for the sender and the receiver; the stimulus
  // process changes them between phases.
  int unsigned send_idle_pct  = 0;
  int unsigned rsp_stall_pct  = 0;
  int unsigned cycle_count    = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // The receiver drops ready at random, at the rate of the current phase.
  initial begin
    rsp_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      rsp_if.ready <= ($urandom_range(99) >= rsp_stall_pct);
    end
  end

  // Monitor: all sampling happens at the rising edge, before the block's
  // registers update, so both channels are seen as they were at the
  // transfer. A response always trails its command.
  always @(posedge clk_i) begin
    spq_rsp_t act;
    if (rst_ni) begin
      if (rsp_if.valid && rsp_if.ready) begin
        act.status    = status_e'(rsp_if.status);
        act.found     = rsp_if.found;
        act.key       = rsp_if.out_key;
        act.prio      = rsp_if.out_priority;
        act.occupancy = rsp_if.occupancy;
        sb.check_response(act);
      end
      if (cmd_if.valid && cmd_if.ready) begin
        sb.note_command(cmd_if.command, cmd_if.key, cmd_if.priority_req);
      end
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Presents one command and holds it until the transfer. Valid stays high
  // from one command to the next unless the sender decides to idle first.
  task automatic issue(logic [1:0] cmd, logic [KeyBits-1:0] key,
                       logic [PrioBits-1:0] prio);
    while ($urandom_range(99) < send_idle_pct) begin
      cmd_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    cmd_if.valid        <= 1'b1;
    cmd_if.command      <= cmd;
    cmd_if.key          <= key;
    cmd_if.priority_req <= prio;
    do @(posedge clk_i); while (!(cmd_if.valid && cmd_if.ready));
  endtask

  // Stops sending and waits until every outstanding response has arrived.
  // The first edge lets the monitor note a command that transferred just now.
  task automatic drain();
    cmd_if.valid <= 1'b0;
    do @(posedge clk_i); while (sb.pending_rsp.size() != 0);
  endtask

  // Random commands. The mix swings between filling and draining in blocks
  // so that the queue runs into both the full and the empty state often.
  // Keys come partly from a small pool or from stored entries so that
  // queries hit and duplicate keys occur; priorities often come from a few
  // values so that ties exercise the arrival-order rule.
  task automatic random_phase(int unsigned n_items);
    int unsigned         i;
    int unsigned         roll;
    int unsigned         insert_pct;
    logic [1:0]          cmd;
    logic [KeyBits-1:0]  key;
    logic [PrioBits-1:0] prio;
    insert_pct = 25;
    for (i = 0; i < n_items; i++) begin
      if (i % 50 == 0) insert_pct = (insert_pct == 75) ? 25 : 75;
      roll = $urandom_range(99);
      if (roll < 2) begin
        cmd = CmdUnused;
      end else if (roll < 22) begin
        cmd = CmdQuery;
      end else if ($urandom_range(99) < insert_pct) begin
        cmd = CmdInsert;
      end else begin
        cmd = CmdPop;
      end
      case ($urandom_range(3))
        0: key = KeyBits'($urandom());
        1: key = KeyBits'($urandom_range(7));
        2: key = (sb.fill > 0) ? sb.slot_key[$urandom_range(sb.fill - 1)]
                               : KeyBits'($urandom());
        default: begin
          case ($urandom_range(3))
            0: key = '0;
            1: key = '1;
            2: key = 16'h5555;
            default: key = 16'hAAAA;
          endcase
        end
      endcase
      if ($urandom_range(1) == 0) begin
        prio = PrioBits'($urandom_range(3) * 85);
      end else begin
        prio = PrioBits'($urandom());
      end
      issue(cmd, key, prio);
    end
  endtask

  initial begin
    cmd_if.valid        <= 1'b0;
    cmd_if.command      <= CmdInsert;
    cmd_if.key          <= '0;
    cmd_if.priority_req <= '0;
    rst_ni              <= 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, back to back: empty cases first, then fill the queue
    // with extreme keys and priorities and several ties, overflow it, look
    // keys up and pop the head.
    issue(CmdPop, 16'h1111, 8'h11);
    issue(CmdQuery, 16'h0000, 8'h00);
    issue(CmdUnused, 16'hFFFF, 8'hFF);
    issue(CmdInsert, 16'hFFFF, 8'h00);
    issue(CmdInsert, 16'h0000, 8'hFF);
    issue(CmdInsert, 16'h5555, 8'h80);
    issue(CmdInsert, 16'hAAAA, 8'h80);
    issue(CmdInsert, 16'h1234, 8'h80);
    issue(CmdInsert, 16'h0001, 8'hFF);
    issue(CmdInsert, 16'h8000, 8'h01);
    issue(CmdInsert, 16'h7FFF, 8'hFE);
    issue(CmdInsert, 16'h00FF, 8'h80);
    issue(CmdInsert, 16'hFF00, 8'h00);
    issue(CmdInsert, 16'h0F0F, 8'h7F);
    issue(CmdInsert, 16'hF0F0, 8'h81);
    issue(CmdInsert, 16'h3C3C, 8'h80);
    issue(CmdInsert, 16'hC3C3, 8'hFF);
    issue(CmdInsert, 16'h6666, 8'h40);
    issue(CmdInsert, 16'h9999, 8'h40);
    issue(CmdInsert, 16'hABCD, 8'hFF);
    issue(CmdQuery, 16'h5555, 8'h00);
    issue(CmdQuery, 16'hABCD, 8'h00);
    issue(CmdUnused, 16'h0000, 8'h00);
    issue(CmdPop, 16'h0000, 8'h00);
    drain();

    // Random phases with different idle patterns. Each ends in a full drain,
    // so the sender also pauses until nothing is outstanding.
    send_idle_pct = 0;
    rsp_stall_pct = 0;
    random_phase(225);
    drain();
    send_idle_pct = 57;
    rsp_stall_pct = 0;
    random_phase(225);
    drain();
    send_idle_pct = 0;
    rsp_stall_pct = 57;
    random_phase(225);
    drain();
    send_idle_pct = 13;
    rsp_stall_pct = 13;
    random_phase(225);
    drain();

    // The response is registered from its command; a few extra edges catch
    // any stray response.
    repeat (5) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending_rsp.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* files.f */
hw/rtl/spq_pkg.sv
hw/rtl/spq_if.sv
hw/rtl/spq_cell.sv
hw/rtl/stable_priority_queue.sv
tb/spq_shadow_pkg.sv
tb/tb_stable_priority_queue.sv
